// File: rtl/trt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trt_pkg: shared definitions for the touch report tracker
// Opcodes, result kinds, register indexes, gesture states and the transform
// configuration bundle.
// ---------------------------------------------------------------------------
package trt_pkg;

    // Input opcodes
    localparam logic [1:0] OP_STATUS = 2'd0;
    localparam logic [1:0] OP_RECORD = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result kinds
    localparam logic [1:0] RK_POINT     = 2'd0;
    localparam logic [1:0] RK_NOT_READY = 2'd1;
    localparam logic [1:0] RK_EMPTY     = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_LONG_PRESS   = 3'd0;
    localparam logic [2:0] CFG_RELEASE_HOLD = 3'd1;
    localparam logic [2:0] CFG_SWAP_XY      = 3'd2;
    localparam logic [2:0] CFG_MIRROR_X     = 3'd3;
    localparam logic [2:0] CFG_MIRROR_Y     = 3'd4;
    localparam logic [2:0] CFG_SCREEN_W     = 3'd5;
    localparam logic [2:0] CFG_SCREEN_H     = 3'd6;

    // Register reset values
    localparam logic [15:0] LONG_PRESS_RST   = 16'd800;
    localparam logic [15:0] RELEASE_HOLD_RST = 16'd40;
    localparam logic [15:0] SCREEN_W_RST     = 16'd800;
    localparam logic [15:0] SCREEN_H_RST     = 16'd480;

    // Report format
    localparam int          MAX_POINTS_DEF = 5;
    localparam int          RECORD_BYTES   = 8;
    localparam logic [2:0]  REC_LAST_IDX   = 3'(RECORD_BYTES - 1);
    localparam logic [7:0]  STATUS_READY   = 8'h80;
    localparam logic [15:0] TIMER_MAX      = 16'hFFFF;

    // Gesture states
    typedef enum logic [1:0] {
        GS_IDLE = 2'd0,
        GS_DOWN = 2'd1,
        GS_LONG = 2'd2
    } t_gesture;

    // Screen transform settings
    typedef struct packed {
        logic        swap_xy;
        logic        mirror_x;
        logic        mirror_y;
        logic [15:0] screen_w;
        logic [15:0] screen_h;
    } t_xform_cfg;

endpackage

// File: rtl/trt_xform.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trt_xform: raw to screen coordinate transform
// Optionally swaps x and y, then mirrors each axis against the screen size
// with 16-bit wrap.
// ---------------------------------------------------------------------------
module trt_xform (
    input  trt_pkg::t_xform_cfg i_cfg,
    input  logic [15:0]         i_raw_x,
    input  logic [15:0]         i_raw_y,
    output logic [15:0]         o_scr_x,
    output logic [15:0]         o_scr_y
);
    import trt_pkg::*;

    logic [15:0] w_sx;
    logic [15:0] w_sy;

    // Swap axes first
    assign w_sx = i_cfg.swap_xy ? i_raw_y : i_raw_x;
    assign w_sy = i_cfg.swap_xy ? i_raw_x : i_raw_y;

    // Mirror, wrapping at 16 bits
    assign o_scr_x = i_cfg.mirror_x ? (i_cfg.screen_w - 16'd1 - w_sx) : w_sx;
    assign o_scr_y = i_cfg.mirror_y ? (i_cfg.screen_h - 16'd1 - w_sy) : w_sy;

endmodule

// File: rtl/touch_report_tracker_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// touch_report_tracker_core: touch report decoder and gesture tracker
// Parses status bytes and point records, keeps the press timer and gesture
// state, and emits one result per completed point, empty report or not-ready status.
// ---------------------------------------------------------------------------
// Each input transfer (status byte, record byte or millisecond tick) is
// handled by the decode and state update, which sit between the state
// registers and a single output register, so one item is taken every cycle
// as long as the output register is empty or drained in the same cycle.
// A result appears on the output in the cycle after the byte that caused it
// (the eighth byte of a point record, or a not-ready or empty status).
// Configuration writes take effect on the next edge and should be made
// while no result is pending.
// ---------------------------------------------------------------------------
module touch_report_tracker_core #(
    parameter int MAX_POINTS = trt_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    // Output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [1:0]  o_touch_state,
    output logic [15:0] o_point_x,
    output logic [15:0] o_point_y,
    output logic [7:0]  o_point_size,
    output logic [3:0]  o_point_id,
    output logic [3:0]  o_point_slot,
    output logic [3:0]  o_point_total,
    output logic        o_last_point
);
    import trt_pkg::*;

    localparam logic [3:0] MAX_CNT = 4'(MAX_POINTS);

    // Configuration registers
    logic [15:0] r_long_press;
    logic [15:0] r_release_hold;
    t_xform_cfg  r_xcfg;

    // Tracker state
    logic        r_pressed,   n_pressed;
    logic [15:0] r_elapsed,   n_elapsed;
    t_gesture    r_gesture,   n_gesture;
    logic [3:0]  r_expected,  n_expected;
    logic [3:0]  r_slot,      n_slot;
    logic [2:0]  r_byte_idx,  n_byte_idx;
    logic [15:0] r_part_x,    n_part_x;
    logic [15:0] r_part_y,    n_part_y;
    logic [7:0]  r_part_size, n_part_size;

    // Output register
    logic        r_out_valid;
    logic [1:0]  r_kind,  n_kind;
    t_gesture    r_state_out;
    logic [15:0] r_px;
    logic [15:0] r_py;
    logic [7:0]  r_psize, n_psize;
    logic [3:0]  r_pid,   n_pid;
    logic [3:0]  r_pslot, n_pslot;
    logic [3:0]  r_ptot,  n_ptot;
    logic        r_plast, n_plast;

    logic        w_in_xfer;
    logic        w_emit;
    logic        w_pt_emit;
    logic [3:0]  w_count;
    logic        w_last;
    logic [15:0] w_scr_x;
    logic [15:0] w_scr_y;

    assign o_ready   = !r_out_valid || i_ready;
    assign w_in_xfer = i_valid && o_ready;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press    <= LONG_PRESS_RST;
            r_release_hold  <= RELEASE_HOLD_RST;
            r_xcfg.swap_xy  <= 1'b0;
            r_xcfg.mirror_x <= 1'b0;
            r_xcfg.mirror_y <= 1'b0;
            r_xcfg.screen_w <= SCREEN_W_RST;
            r_xcfg.screen_h <= SCREEN_H_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LONG_PRESS:   r_long_press    <= i_cfg_data;
                CFG_RELEASE_HOLD: r_release_hold  <= i_cfg_data;
                CFG_SWAP_XY:      r_xcfg.swap_xy  <= i_cfg_data[0];
                CFG_MIRROR_X:     r_xcfg.mirror_x <= i_cfg_data[0];
                CFG_MIRROR_Y:     r_xcfg.mirror_y <= i_cfg_data[0];
                CFG_SCREEN_W:     r_xcfg.screen_w <= i_cfg_data;
                CFG_SCREEN_H:     r_xcfg.screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Transform the completed record
    trt_xform u_xform (
        .i_cfg   (r_xcfg),
        .i_raw_x (r_part_x),
        .i_raw_y (r_part_y),
        .o_scr_x (w_scr_x),
        .o_scr_y (w_scr_y)
    );

    assign w_count = (i_data_byte[3:0] > MAX_CNT) ? MAX_CNT : i_data_byte[3:0];
    assign w_last  = ({1'b0, r_slot} + 5'd1) >= {1'b0, r_expected};

    // Decode one item and compute the next tracker state
    always_comb begin
        n_pressed   = r_pressed;
        n_elapsed   = r_elapsed;
        n_gesture   = r_gesture;
        n_expected  = r_expected;
        n_slot      = r_slot;
        n_byte_idx  = r_byte_idx;
        n_part_x    = r_part_x;
        n_part_y    = r_part_y;
        n_part_size = r_part_size;
        w_emit      = 1'b0;
        w_pt_emit   = 1'b0;
        n_kind      = RK_POINT;
        n_psize     = 8'd0;
        n_pid       = 4'd0;
        n_pslot     = 4'd0;
        n_ptot      = 4'd0;
        n_plast     = 1'b0;

        case (i_opcode)
            OP_STATUS: begin
                n_expected = 4'd0;
                n_slot     = 4'd0;
                n_byte_idx = 3'd0;
                if ((i_data_byte & STATUS_READY) == 8'd0 || w_count == 4'd0) begin
                    // Empty or not-ready report: release check and report
                    w_emit = 1'b1;
                    n_kind = ((i_data_byte & STATUS_READY) == 8'd0) ? RK_NOT_READY
                                                                    : RK_EMPTY;
                    if (!r_pressed) begin
                        n_gesture = GS_IDLE;
                    end else if (r_elapsed >= r_release_hold) begin
                        n_pressed = 1'b0;
                        n_gesture = GS_IDLE;
                    end
                end else begin
                    // Open a report and update the press
                    n_expected = w_count;
                    if (!r_pressed) begin
                        n_pressed = 1'b1;
                        n_elapsed = 16'd0;
                        n_gesture = GS_DOWN;
                    end else if (r_elapsed >= r_long_press) begin
                        n_gesture = GS_LONG;
                    end else begin
                        n_gesture = GS_DOWN;
                    end
                end
            end
            OP_TICK: begin
                if (r_pressed && r_elapsed != TIMER_MAX) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
            end
            OP_RECORD: begin
                if (r_slot < r_expected) begin
                    case (r_byte_idx)
                        3'd0: n_part_x[7:0]  = i_data_byte;
                        3'd1: n_part_x[15:8] = i_data_byte;
                        3'd2: n_part_y[7:0]  = i_data_byte;
                        3'd3: n_part_y[15:8] = i_data_byte;
                        3'd4: n_part_size    = i_data_byte;
                        default: ;
                    endcase
                    if (r_byte_idx != REC_LAST_IDX) begin
                        n_byte_idx = r_byte_idx + 3'd1;
                    end else begin
                        // Record complete: emit the point
                        w_emit     = 1'b1;
                        w_pt_emit  = 1'b1;
                        n_psize    = r_part_size;
                        n_pid      = i_data_byte[3:0];
                        n_pslot    = r_slot;
                        n_ptot     = r_expected;
                        n_plast    = w_last;
                        n_byte_idx = 3'd0;
                        if (w_last) begin
                            n_expected = 4'd0;
                            n_slot     = 4'd0;
                        end else begin
                            n_slot = r_slot + 4'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Tracker state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed   <= 1'b0;
            r_elapsed   <= 16'd0;
            r_gesture   <= GS_IDLE;
            r_expected  <= 4'd0;
            r_slot      <= 4'd0;
            r_byte_idx  <= 3'd0;
            r_part_x    <= 16'd0;
            r_part_y    <= 16'd0;
            r_part_size <= 8'd0;
        end else if (w_in_xfer) begin
            r_pressed   <= n_pressed;
            r_elapsed   <= n_elapsed;
            r_gesture   <= n_gesture;
            r_expected  <= n_expected;
            r_slot      <= n_slot;
            r_byte_idx  <= n_byte_idx;
            r_part_x    <= n_part_x;
            r_part_y    <= n_part_y;
            r_part_size <= n_part_size;
        end
    end

    // Output valid: load on a result, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_emit) begin
            r_kind      <= n_kind;
            r_state_out <= n_gesture;
            r_px        <= w_pt_emit ? w_scr_x : 16'd0;
            r_py        <= w_pt_emit ? w_scr_y : 16'd0;
            r_psize     <= n_psize;
            r_pid       <= n_pid;
            r_pslot     <= n_pslot;
            r_ptot      <= n_ptot;
            r_plast     <= n_plast;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_touch_state = r_state_out;
    assign o_point_x     = r_px;
    assign o_point_y     = r_py;
    assign o_point_size  = r_psize;
    assign o_point_id    = r_pid;
    assign o_point_slot  = r_pslot;
    assign o_point_total = r_ptot;
    assign o_last_point  = r_plast;

    // A released tracker is always idle
    a_release_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pressed |-> (r_gesture == GS_IDLE))
        else $error("tracker released but gesture not idle");

    // Slot stays inside the open report
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_expected <= MAX_CNT) &&
        ((r_expected == 4'd0) ? (r_slot == 4'd0) : (r_slot < r_expected)))
        else $error("report slot out of range");

    // A point report carries a slot inside its total
    a_point_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == RK_POINT) |->
        (o_point_slot < o_point_total) &&
        (o_last_point == (o_point_slot + 4'd1 == o_point_total)))
        else $error("point report slot inconsistent");

    // A tick while pressed advances the timer by one until it saturates
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_opcode == OP_TICK && r_pressed && r_elapsed != TIMER_MAX)
        |=> (r_elapsed == $past(r_elapsed) + 16'd1))
        else $error("press timer did not advance");

endmodule
